// ----- hdl/nrpc_pkg.sv -----
// ----------------------------------------------------------------------------
// nrpc_pkg
// Shared types and constants for the nested region profile counters.
// ----------------------------------------------------------------------------
package nrpc_pkg;

    localparam int OP_W           = 2;
    localparam int IDX_W          = 8;
    localparam int CNT_W          = 64;
    localparam int IDX_VALUES     = 1 << IDX_W;
    localparam int DEF_REGIONS    = 256;
    localparam int DEF_NEST_DEPTH = 16;

    // item operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ENTER = 2'd0,
        OP_EXIT  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_ZERO  = 2'd3
    } status_t;

    // one row of the counter table, exclusive time in the low bits
    typedef struct packed {
        logic [CNT_W-1:0] byte_total;
        logic [CNT_W-1:0] hit_count;
        logic [CNT_W-1:0] inclusive_ticks;
        logic [CNT_W-1:0] exclusive_ticks;
    } counters_t;

    // input item without the region index
    typedef struct packed {
        logic [CNT_W-1:0] byte_count;
        logic [CNT_W-1:0] timestamp;
        op_t              operation;
    } req_t;

    // result item, status in the low bits
    typedef struct packed {
        counters_t cnt;
        status_t   status;
    } result_t;

endpackage

// ----- hdl/nrpc_ram.sv -----
// ----------------------------------------------------------------------------
// nrpc_ram
// Generic simple dual port RAM, one write and one registered read port.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module nrpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/nrpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// nrpc_ctrl
// Sequencer for the region counter table and the open region stack.
// Holds both memories and does the read, modify and write back of each item.
// ----------------------------------------------------------------------------
module nrpc_ctrl #(
    parameter int REGIONS    = nrpc_pkg::DEF_REGIONS,
    parameter int NEST_DEPTH = nrpc_pkg::DEF_NEST_DEPTH,
    localparam int RIDX_W    = $clog2(REGIONS)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  nrpc_pkg::req_t      in_req,
    input  logic [RIDX_W-1:0]   in_idx,
    output logic                res_valid,
    input  logic                res_ready,
    output nrpc_pkg::result_t   res
);

    import nrpc_pkg::*;

    localparam int DEPTH_W = $clog2(NEST_DEPTH + 1);
    localparam int SIDX_W  = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int TBL_W   = $bits(counters_t);
    localparam logic [RIDX_W-1:0]  LAST_REGION = RIDX_W'(REGIONS - 1);
    localparam logic [DEPTH_W-1:0] FULL_DEPTH  = DEPTH_W'(NEST_DEPTH);

    typedef struct packed {
        logic [RIDX_W-1:0] region;
        logic [RIDX_W-1:0] parent;
        logic [CNT_W-1:0]  start;
        logic [CNT_W-1:0]  prior;
        logic [CNT_W-1:0]  nbytes;
    } frame_t;

    localparam int FRAME_W = $bits(frame_t);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ENTER_WR,
        S_READ_DATA,
        S_EXIT_FRAME,
        S_EXIT_REGION,
        S_EXIT_PARENT,
        S_EMIT
    } state_t;

    // control state
    state_t               state_reg,    state_next;
    logic [RIDX_W-1:0]    clr_addr_reg, clr_addr_next;
    logic [DEPTH_W-1:0]   depth_reg,    depth_next;
    logic [RIDX_W-1:0]    cur_reg,      cur_next;

    // item payload
    logic [RIDX_W-1:0]    idx_reg,      idx_next;
    logic [CNT_W-1:0]     ts_reg,       ts_next;
    logic [CNT_W-1:0]     bytes_reg,    bytes_next;
    logic [RIDX_W-1:0]    region_reg,   region_next;
    logic [RIDX_W-1:0]    parent_reg,   parent_next;
    logic [CNT_W-1:0]     elapsed_reg,  elapsed_next;
    logic [CNT_W-1:0]     prior_reg,    prior_next;
    logic [CNT_W-1:0]     fbytes_reg,   fbytes_next;
    status_t              res_status_reg, res_status_next;
    counters_t            res_cnt_reg,  res_cnt_next;

    // memory ports
    logic                 tbl_we;
    logic [RIDX_W-1:0]    tbl_waddr;
    counters_t            tbl_wdata;
    logic [RIDX_W-1:0]    tbl_raddr;
    counters_t            tbl_rdata;
    logic                 stk_we;
    logic [SIDX_W-1:0]    stk_waddr;
    frame_t               stk_wdata;
    logic [SIDX_W-1:0]    stk_raddr;
    frame_t               stk_rdata;

    logic [DEPTH_W-1:0]   depth_m1;
    counters_t            r_new;
    counters_t            p_cur;
    counters_t            p_new;

    nrpc_ram #(
        .WIDTH (TBL_W),
        .DEPTH (REGIONS)
    ) u_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    nrpc_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (NEST_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // counter updates of an exit
    assign depth_m1 = depth_reg - 1'b1;

    always_comb begin
        r_new                 = tbl_rdata;
        r_new.exclusive_ticks = tbl_rdata.exclusive_ticks + elapsed_reg;
        r_new.inclusive_ticks = prior_reg + elapsed_reg;
        r_new.hit_count       = tbl_rdata.hit_count + 1'b1;
        r_new.byte_total      = tbl_rdata.byte_total + fbytes_reg;
    end

    // parent read was issued while the region was being written back
    assign p_cur = (parent_reg == region_reg) ? res_cnt_reg : tbl_rdata;

    always_comb begin
        p_new                 = p_cur;
        p_new.exclusive_ticks = p_cur.exclusive_ticks - elapsed_reg;
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        depth_next      = depth_reg;
        cur_next        = cur_reg;
        idx_next        = idx_reg;
        ts_next         = ts_reg;
        bytes_next      = bytes_reg;
        region_next     = region_reg;
        parent_next     = parent_reg;
        elapsed_next    = elapsed_reg;
        prior_next      = prior_reg;
        fbytes_next     = fbytes_reg;
        res_status_next = res_status_reg;
        res_cnt_next    = res_cnt_reg;

        tbl_we    = 1'b0;
        tbl_waddr = region_reg;
        tbl_wdata = r_new;
        tbl_raddr = in_idx;
        stk_we    = 1'b0;
        stk_waddr = depth_reg[SIDX_W-1:0];
        stk_wdata = '{region: idx_reg, parent: cur_reg, start: ts_reg,
                      prior: tbl_rdata.inclusive_ticks, nbytes: bytes_reg};
        stk_raddr = depth_m1[SIDX_W-1:0];

        case (state_reg)
            S_CLEAR: begin
                tbl_we        = 1'b1;
                tbl_waddr     = clr_addr_reg;
                tbl_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_REGION) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_valid) begin
                    idx_next        = in_idx;
                    ts_next         = in_req.timestamp;
                    bytes_next      = in_req.byte_count;
                    res_status_next = ST_OK;
                    res_cnt_next    = '0;
                    case (in_req.operation)
                        OP_ENTER: begin
                            if (in_idx == '0) begin
                                res_status_next = ST_ZERO;
                                state_next      = S_EMIT;
                            end else if (depth_reg == FULL_DEPTH) begin
                                res_status_next = ST_FULL;
                                state_next      = S_EMIT;
                            end else begin
                                state_next = S_ENTER_WR;
                            end
                        end
                        OP_EXIT: begin
                            if (depth_reg == '0) begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_EMIT;
                            end else begin
                                state_next = S_EXIT_FRAME;
                            end
                        end
                        OP_READ: begin
                            if (in_idx == '0) begin
                                res_status_next = ST_ZERO;
                                state_next      = S_EMIT;
                            end else begin
                                state_next = S_READ_DATA;
                            end
                        end
                        default: begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            // push the frame with the inclusive time seen at entry
            S_ENTER_WR: begin
                stk_we     = 1'b1;
                depth_next = depth_reg + 1'b1;
                cur_next   = idx_reg;
                state_next = S_EMIT;
            end
            S_READ_DATA: begin
                res_cnt_next = tbl_rdata;
                state_next   = S_EMIT;
            end
            // pop the frame and fetch the region row
            S_EXIT_FRAME: begin
                region_next  = stk_rdata.region;
                parent_next  = stk_rdata.parent;
                elapsed_next = ts_reg - stk_rdata.start;
                prior_next   = stk_rdata.prior;
                fbytes_next  = stk_rdata.nbytes;
                tbl_raddr    = stk_rdata.region;
                depth_next   = depth_m1;
                cur_next     = stk_rdata.parent;
                state_next   = S_EXIT_REGION;
            end
            // write back the region and fetch the parent row
            S_EXIT_REGION: begin
                tbl_we       = 1'b1;
                tbl_waddr    = region_reg;
                tbl_wdata    = r_new;
                res_cnt_next = r_new;
                tbl_raddr    = parent_reg;
                state_next   = S_EXIT_PARENT;
            end
            // take the elapsed time off the parent
            S_EXIT_PARENT: begin
                tbl_we    = 1'b1;
                tbl_waddr = parent_reg;
                tbl_wdata = p_new;
                if (parent_reg == region_reg) begin
                    res_cnt_next = p_new;
                end
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            depth_reg    <= '0;
            cur_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            depth_reg    <= depth_next;
            cur_reg      <= cur_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        ts_reg         <= ts_next;
        bytes_reg      <= bytes_next;
        region_reg     <= region_next;
        parent_reg     <= parent_next;
        elapsed_reg    <= elapsed_next;
        prior_reg      <= prior_next;
        fbytes_reg     <= fbytes_next;
        res_status_reg <= res_status_next;
        res_cnt_reg    <= res_cnt_next;
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_EMIT);
    assign res.status = res_status_reg;
    assign res.cnt    = res_cnt_reg;

endmodule

// ----- hdl/nested_region_profile_counters.sv -----
// ----------------------------------------------------------------------------
// nested_region_profile_counters
// Hierarchical region profiler: counter table per region and a stack of
// open regions, driven by enter, exit and read transfers.
// ----------------------------------------------------------------------------
// Rejected items and op code three go straight to the result; enter pushes
// a stack frame, read fetches the row, and exit pops a frame, then writes
// back the region row and the parent row through the single read and write
// port of the counter table RAM. One item is worked on at a time.
// The output register holds a result while the next item is being accepted.
// After reset the counter table is cleared row by row, s_tready low.
// ----------------------------------------------------------------------------
module nested_region_profile_counters #(
    parameter int REGIONS    = nrpc_pkg::DEF_REGIONS,
    parameter int NEST_DEPTH = nrpc_pkg::DEF_NEST_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation, region_index, timestamp, byte_count
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, exclusive_ticks, inclusive_ticks, hit_count, byte_total
    output logic [263:0] m_tdata
);

    import nrpc_pkg::*;

    localparam int RIDX_W = $clog2(REGIONS);

    req_t              in_req;
    logic [IDX_W-1:0]  in_raw_idx;
    logic [RIDX_W-1:0] in_idx;
    logic [RIDX_W-1:0] idx_mod_tbl [IDX_VALUES];
    logic              res_valid;
    logic              res_ready;
    result_t           res;
    logic              m_tvalid_reg;
    result_t           m_data_reg;

    // unpack the input transfer
    assign in_req.operation  = op_t'(s_tdata[1:0]);
    assign in_raw_idx        = s_tdata[9:2];
    assign in_req.timestamp  = s_tdata[73:10];
    assign in_req.byte_count = s_tdata[137:74];

    // region index folded into the table range
    for (genvar i = 0; i < IDX_VALUES; i++) begin : g_idx_mod
        assign idx_mod_tbl[i] = RIDX_W'(i % REGIONS);
    end

    assign in_idx = idx_mod_tbl[in_raw_idx];

    nrpc_ctrl #(
        .REGIONS    (REGIONS),
        .NEST_DEPTH (NEST_DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (in_req),
        .in_idx    (in_idx),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_data_reg};

endmodule

// ----- bench/nested_region_profile_counters_test.sv -----
// ----------------------------------------------------------------------------
// nested_region_profile_counters_test
// Self-checking bench for the nested region profiler. A scoreboard keeps its
// own copy of the counter table and the open-region stack and predicts
// every result. Directed items cover the rejects, wrap of the timestamp
// difference, recursion and a full stack. Random enter and exit sequences
// follow, mixed with reads and noise, with random stalls on both channels.
// ----------------------------------------------------------------------------
module nested_region_profile_counters_test;
    import nrpc_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 360;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int STACK_DEPTH  = DEF_NEST_DEPTH;
    localparam int IDLE_PCT     = 6;

    // one profiler command as queued for the driver
    typedef struct {
        op_t              operation;
        logic [IDX_W-1:0] region;
        logic [CNT_W-1:0] stamp;
        logic [CNT_W-1:0] nbytes;
    } prof_cmd_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [263:0] m_tdata;

    nested_region_profile_counters DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // commands waiting for the driver and results waiting for the dut
    prof_cmd_t cmd_q[$];
    result_t   expected_q[$];
    prof_cmd_t drv_item;
    logic      in_fire;
    int        gen_depth;
    int        sent_count;
    int        rcv_count;
    int        err_count;
    int        cycle_count;

    // scoreboard copy of the counter table and the open-region stack
    logic [CNT_W-1:0] excl_ticks [DEF_REGIONS];
    logic [CNT_W-1:0] incl_ticks [DEF_REGIONS];
    logic [CNT_W-1:0] hit_ticks  [DEF_REGIONS];
    logic [CNT_W-1:0] byte_sums  [DEF_REGIONS];
    logic [IDX_W-1:0] stk_region [STACK_DEPTH];
    logic [IDX_W-1:0] stk_parent [STACK_DEPTH];
    logic [CNT_W-1:0] stk_start  [STACK_DEPTH];
    logic [CNT_W-1:0] stk_prior  [STACK_DEPTH];
    logic [CNT_W-1:0] stk_bytes  [STACK_DEPTH];
    int               open_frames;
    logic [IDX_W-1:0] inner_region;

    function automatic logic [CNT_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly a small set of regions so reads and recursion hit live entries
    function automatic logic [IDX_W-1:0] pick_region();
        if ($urandom_range(0, 3) == 0)
            return IDX_W'($urandom_range(1, 255));
        return IDX_W'($urandom_range(1, 12));
    endfunction

    function automatic bit take_break(int count, int quiet_lo, int quiet_hi);
        if (count >= quiet_lo && count < quiet_hi)
            return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    // queue a command and track the stack depth it leaves behind
    task automatic queue_cmd(op_t op, logic [IDX_W-1:0] r, logic [CNT_W-1:0] ts,
                             logic [CNT_W-1:0] nb);
        prof_cmd_t c;
        c.operation = op;
        c.region    = r;
        c.stamp     = ts;
        c.nbytes    = nb;
        cmd_q.push_back(c);
        if (op == OP_ENTER && r != '0 && gen_depth < STACK_DEPTH)
            gen_depth++;
        else if (op == OP_EXIT && gen_depth > 0)
            gen_depth--;
    endtask

    // update the scoreboard state for one accepted command, queue its result
    task automatic predict_counters(prof_cmd_t c);
        result_t          res;
        int               d;
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] p;
        logic [CNT_W-1:0] elapsed;
        res        = '0;
        res.status = ST_OK;
        r          = c.region;
        case (c.operation)
            OP_ENTER: begin
                if (c.region == '0) begin
                    res.status = ST_ZERO;
                end else if (open_frames >= STACK_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    d = open_frames;
                    stk_region[d] = c.region;
                    stk_parent[d] = inner_region;
                    stk_start[d]  = c.stamp;
                    stk_prior[d]  = incl_ticks[c.region];
                    stk_bytes[d]  = c.nbytes;
                    open_frames   = d + 1;
                    inner_region  = c.region;
                end
            end
            OP_EXIT: begin
                if (open_frames == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    d            = open_frames - 1;
                    r            = stk_region[d];
                    p            = stk_parent[d];
                    elapsed      = c.stamp - stk_start[d];
                    open_frames  = d;
                    inner_region = p;
                    // same entry for a region nested in itself: the two cancel
                    excl_ticks[p] = excl_ticks[p] - elapsed;
                    excl_ticks[r] = excl_ticks[r] + elapsed;
                    incl_ticks[r] = stk_prior[d] + elapsed;
                    byte_sums[r]  = byte_sums[r] + stk_bytes[d];
                    hit_ticks[r]  = hit_ticks[r] + 1;
                end
            end
            OP_READ: begin
                if (c.region == '0)
                    res.status = ST_ZERO;
            end
            default: ;
        endcase
        // counters shown after a good exit or a good read
        if (res.status == ST_OK && (c.operation == OP_EXIT || c.operation == OP_READ)) begin
            res.cnt.exclusive_ticks = excl_ticks[r];
            res.cnt.inclusive_ticks = incl_ticks[r];
            res.cnt.hit_count       = hit_ticks[r];
            res.cnt.byte_total      = byte_sums[r];
        end
        expected_q.push_back(res);
    endtask

    task automatic check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
        if (got !== want) begin
            $error("%s expected %h got %h", name, want, got);
            err_count++;
        end
    endtask

    // clock
    always begin
        aclk = 1'b1;
        #HALF_PERIOD;
        aclk = 1'b0;
        #HALF_PERIOD;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // input driver and result channel back-pressure
    always @(negedge aclk) begin : driver
        prof_cmd_t c;
        logic      next_valid;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            next_valid = s_tvalid && !in_fire;
            if (!next_valid && cmd_q.size() != 0 && !take_break(sent_count, 200, 320)) begin
                c = cmd_q.pop_front();
                drv_item   <= c;
                s_tdata    <= {6'b0, c.nbytes, c.stamp, c.region, c.operation};
                next_valid = 1'b1;
            end
            s_tvalid <= next_valid;
            m_tready <= !take_break(rcv_count, 60, 180);
        end
    end

    // result checking and prediction on each input transfer
    always @(posedge aclk) begin : monitor
        result_t got;
        result_t want;
        if (!aresetn) begin
            in_fire <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[$bits(result_t)-1:0]);
                rcv_count++;
                if (expected_q.size() == 0) begin
                    $error("result transfer with nothing expected, status %0d", got.status);
                    err_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("status", CNT_W'(want.status), CNT_W'(got.status));
                    check_field("exclusive_ticks", want.cnt.exclusive_ticks,
                                got.cnt.exclusive_ticks);
                    check_field("inclusive_ticks", want.cnt.inclusive_ticks,
                                got.cnt.inclusive_ticks);
                    check_field("hit_count", want.cnt.hit_count, got.cnt.hit_count);
                    check_field("byte_total", want.cnt.byte_total, got.cnt.byte_total);
                end
            end
            if (s_tvalid && s_tready) begin
                predict_counters(drv_item);
                sent_count++;
            end
            in_fire <= s_tvalid && s_tready;
        end
    end

    // stimulus, reset and end of run
    initial begin : stimulus
        logic [CNT_W-1:0] now;
        logic [CNT_W-1:0] ts;
        logic [CNT_W-1:0] nb;
        int               sel;
        int               k;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        drv_item     = '{OP_NONE, '0, '0, '0};
        in_fire      = 1'b0;
        gen_depth    = 0;
        sent_count   = 0;
        rcv_count    = 0;
        err_count    = 0;
        cycle_count  = 0;
        open_frames  = 0;
        inner_region = '0;
        for (k = 0; k < DEF_REGIONS; k++) begin
            excl_ticks[k] = '0;
            incl_ticks[k] = '0;
            hit_ticks[k]  = '0;
            byte_sums[k]  = '0;
        end

        // rejects, op code three and a never-visited region
        queue_cmd(OP_READ, '0, '0, '0);
        queue_cmd(OP_ENTER, '0, rand64(), rand64());
        queue_cmd(OP_EXIT, 8'hFF, '1, '1);
        queue_cmd(OP_NONE, 8'hFF, '1, '1);
        queue_cmd(OP_READ, 8'hFF, '0, '0);
        // elapsed time wraps past zero
        queue_cmd(OP_ENTER, 8'hFF, 64'hFFFF_FFFF_FFFF_FFF0, '1);
        queue_cmd(OP_EXIT, 8'h00, 64'h10, '0);
        // fill the stack, region one nested in itself, then one too many
        now = rand64();
        for (k = 0; k < STACK_DEPTH; k++) begin
            now = now + CNT_W'(k * 7 + 3);
            queue_cmd(OP_ENTER, IDX_W'(k == 0 ? 1 : k), now, CNT_W'(k));
        end
        queue_cmd(OP_ENTER, 8'h80, now + 1, rand64());
        queue_cmd(OP_EXIT, 8'h00, now + 50, '0);

        // random sequences, mostly well-formed nesting
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            now = now + CNT_W'($urandom_range(1, 5000));
            ts  = ($urandom_range(0, 99) < 3) ? rand64() : now;
            nb  = $urandom_range(0, 1) ? rand64() : CNT_W'($urandom_range(0, 4096));
            sel = $urandom_range(0, 99);
            if (sel < 2) begin
                // dive to a full stack and push once more
                while (gen_depth < STACK_DEPTH) begin
                    now = now + CNT_W'($urandom_range(1, 500));
                    queue_cmd(OP_ENTER, pick_region(), now, nb);
                end
                queue_cmd(OP_ENTER, pick_region(), now, nb);
            end else if (sel < 8) begin
                queue_cmd(op_t'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 255)),
                          rand64(), rand64());
            end else if (sel < 23) begin
                queue_cmd(OP_READ, pick_region(), ts, nb);
            end else if (gen_depth == 0 || (gen_depth < STACK_DEPTH && sel < 62)) begin
                queue_cmd(OP_ENTER, pick_region(), ts, nb);
            end else begin
                queue_cmd(OP_EXIT, IDX_W'($urandom_range(0, 255)), ts, nb);
            end
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (cmd_q.size() != 0 || s_tvalid || expected_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/nrpc_pkg.sv
hdl/nrpc_ram.sv
hdl/nrpc_ctrl.sv
hdl/nested_region_profile_counters.sv
bench/nested_region_profile_counters_test.sv
